@@ hdl/vad_pkg.sv @@
// Shared constants and types for the voice activity detector.
// Depends on nothing; the top level refers to it by scoped names.
package vad_pkg;

  // Field widths of the sample and result words.
  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 17;
  localparam int SQUARE_W    = 31;
  localparam int ENERGY_W    = 31;
  localparam int FLEN_W      = 13;
  localparam int RATE_W      = 16;
  localparam int CONF_W      = 9;
  localparam int CROSS_OUT_W = 12;
  localparam int COUNT_W     = 32;

  // Configuration port geometry.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Register indexes, taken from the word address.
  typedef enum logic [1:0] {
    REG_FRAME_LENGTH     = 2'd0,
    REG_ENERGY_THRESHOLD = 2'd1,
    REG_RATE_LOW         = 2'd2,
    REG_RATE_HIGH        = 2'd3
  } reg_idx_t;

  // Register values after reset.
  localparam logic [FLEN_W-1:0]   FRAME_LENGTH_RST = 13'd256;
  localparam logic [ENERGY_W-1:0] THRESHOLD_RST    = 31'd10737418;
  localparam logic [RATE_W-1:0]   RATE_LOW_RST     = 16'd6554;
  localparam logic [RATE_W-1:0]   RATE_HIGH_RST    = 16'd19661;

  // Shortest frame that is honoured.
  localparam int FRAME_MIN = 2;

  // Confidence of a voice frame: 1.0 in Q1.8.
  localparam logic [CONF_W-1:0] CONF_ONE = 9'd256;

  // Saturation value of the frame counters.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

  // Sequencer states of the top level.
  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_HIST = 4'b0100,
    ST_DEC  = 4'b1000
  } state_t;

endpackage

@@ hdl/vad_div.sv @@
// Restoring divider, one quotient bit per cycle, used for the frame mean energy.
// Stand-alone; instantiated by the voice activity detector top level.
module vad_div #(
  parameter int DW = 43,
  parameter int VW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int KW = $clog2(DW + 1);

  logic [DW-1:0] quo_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [KW-1:0] cnt_r;
  logic          done_r;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_nxt;

  // One trial subtraction per step; the remainder always stays below the divisor.
  always_comb begin
    trial   = {rem_r, quo_r[DW-1]};
    ge      = trial >= {1'b0, dvs_r};
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[VW-1:0] : trial[VW-1:0];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= KW'(DW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == KW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ hdl/voice_activity_detector.sv @@
// Voice activity detector top level: frame accumulation, history memory and decision.
// Depends on vad_pkg and vad_div.
// Usage. Samples arrive on the in_ channel as signed 16-bit words and are
// accepted at an edge where in_valid is high and in_stall low. Every
// frame_length samples, clamped to FRAME_MIN..MAX_FRAME, the block issues one
// result word on the out_ channel: the voice flag, its confidence, the mean
// frame energy, the crossing count and the two saturating frame counters.
// Throughput: one sample per cycle within a frame. The last sample of a frame
// starts a bit-serial divider of SW = clog2(MAX_FRAME+1)+30 steps (43 at the
// default MAX_FRAME), followed by the history read-modify-write state and the
// decision state; in_stall stays high from that sample until the decision
// state has loaded the result word into the output register.
// The result sits in an output register; while the receiver stalls it holds
// and samples of the next frame are still accepted. Only the decision of a
// second frame waits for that register to empty.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// frame accumulators and counters, and marks every history entry empty, so
// empty entries read as zero energy. APB registers lie at 0x0, 0x4, 0x8, 0xC.
module voice_activity_detector #(
  parameter int HISTORY_DEPTH = 16,
  parameter int MAX_FRAME     = 4096
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Sample channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [vad_pkg::SAMPLE_W-1:0]   in_sample,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_voice_active,
  output logic [vad_pkg::CONF_W-1:0]            out_confidence,
  output logic [vad_pkg::ENERGY_W-1:0]          out_frame_energy,
  output logic [vad_pkg::CROSS_OUT_W-1:0]       out_crossing_count,
  output logic [vad_pkg::COUNT_W-1:0]           out_voice_frames,
  output logic [vad_pkg::COUNT_W-1:0]           out_silence_frames,
  // Configuration port.
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [vad_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [vad_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [vad_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int CW   = $clog2(MAX_FRAME);
  localparam int NW   = $clog2(MAX_FRAME + 1);
  localparam int SW   = NW + 30;
  localparam int LW   = (NW > vad_pkg::FLEN_W) ? NW : vad_pkg::FLEN_W;
  localparam int HW   = $clog2(HISTORY_DEPTH);
  localparam int TW   = $clog2(HISTORY_DEPTH + 1) + 30;
  localparam int PW   = CW + vad_pkg::RATE_W;
  localparam int CXW  = (CW > vad_pkg::CROSS_OUT_W) ? CW : vad_pkg::CROSS_OUT_W;
  localparam int EW   = vad_pkg::ENERGY_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [vad_pkg::FLEN_W-1:0] frame_length_r;
  logic [EW-1:0]              threshold_r;
  logic [vad_pkg::RATE_W-1:0] rate_low_r;
  logic [vad_pkg::RATE_W-1:0] rate_high_r;

  logic              cfg_wr;
  vad_pkg::reg_idx_t cfg_idx;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = vad_pkg::reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= vad_pkg::FRAME_LENGTH_RST;
      threshold_r    <= vad_pkg::THRESHOLD_RST;
      rate_low_r     <= vad_pkg::RATE_LOW_RST;
      rate_high_r    <= vad_pkg::RATE_HIGH_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vad_pkg::REG_FRAME_LENGTH:     frame_length_r <= cfg_pwdata[vad_pkg::FLEN_W-1:0];
        vad_pkg::REG_ENERGY_THRESHOLD: threshold_r    <= cfg_pwdata[EW-1:0];
        vad_pkg::REG_RATE_LOW:         rate_low_r     <= cfg_pwdata[vad_pkg::RATE_W-1:0];
        vad_pkg::REG_RATE_HIGH:        rate_high_r    <= cfg_pwdata[vad_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      vad_pkg::REG_FRAME_LENGTH:     cfg_prdata = vad_pkg::CFG_DATA_W'(frame_length_r);
      vad_pkg::REG_ENERGY_THRESHOLD: cfg_prdata = vad_pkg::CFG_DATA_W'(threshold_r);
      vad_pkg::REG_RATE_LOW:         cfg_prdata = vad_pkg::CFG_DATA_W'(rate_low_r);
      vad_pkg::REG_RATE_HIGH:        cfg_prdata = vad_pkg::CFG_DATA_W'(rate_high_r);
      default:                       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  vad_pkg::state_t state_r;
  vad_pkg::state_t state_nxt;

  logic in_fire;
  logic out_free;
  logic frame_end;
  logic div_done;

  assign in_stall = (state_r != vad_pkg::ST_ACC);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    unique case (state_r)
      vad_pkg::ST_ACC:  state_nxt = (in_fire && frame_end) ? vad_pkg::ST_DIV : vad_pkg::ST_ACC;
      vad_pkg::ST_DIV:  state_nxt = div_done ? vad_pkg::ST_HIST : vad_pkg::ST_DIV;
      vad_pkg::ST_HIST: state_nxt = vad_pkg::ST_DEC;
      vad_pkg::ST_DEC:  state_nxt = out_free ? vad_pkg::ST_ACC : vad_pkg::ST_DEC;
      default:          state_nxt = vad_pkg::ST_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vad_pkg::ST_ACC;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame accumulation
  // ---------------------------------------------------------------------------
  logic [CW-1:0] pos_r;
  logic          prev_neg_r;
  logic [SW-1:0] sum_r;
  logic [CW-1:0] cross_r;

  logic                        neg;
  logic [vad_pkg::MAG_W-1:0]   mag;
  logic [vad_pkg::SQUARE_W-1:0] sq;
  logic [SW-1:0]               sum_add;
  logic [CW-1:0]               cross_add;
  logic [NW-1:0]               n_cur;
  logic [LW-1:0]               flen_ext;
  logic [LW-1:0]               eff_len;

  // Magnitude, square and sign change of the incoming word.
  always_comb begin
    neg       = in_sample[vad_pkg::SAMPLE_W-1];
    mag       = neg ? vad_pkg::MAG_W'(-$signed({in_sample[vad_pkg::SAMPLE_W-1], in_sample}))
                    : vad_pkg::MAG_W'(in_sample);
    sq        = vad_pkg::SQUARE_W'(mag) * vad_pkg::SQUARE_W'(mag);
    sum_add   = sum_r + SW'(sq);
    cross_add = ((pos_r != '0) && (neg != prev_neg_r)) ? cross_r + 1'b1 : cross_r;
    n_cur     = NW'(pos_r) + 1'b1;
  end

  // Effective frame length, clamped to the supported range.
  always_comb begin
    flen_ext = LW'(frame_length_r);
    if (flen_ext < LW'(vad_pkg::FRAME_MIN)) begin
      eff_len = LW'(vad_pkg::FRAME_MIN);
    end else if (flen_ext > LW'(MAX_FRAME)) begin
      eff_len = LW'(MAX_FRAME);
    end else begin
      eff_len = flen_ext;
    end
    frame_end = LW'(n_cur) >= eff_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      prev_neg_r <= 1'b0;
      sum_r      <= '0;
      cross_r    <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        pos_r      <= '0;
        prev_neg_r <= 1'b0;
        sum_r      <= '0;
        cross_r    <= '0;
      end else begin
        pos_r      <= CW'(n_cur);
        prev_neg_r <= neg;
        sum_r      <= sum_add;
        cross_r    <= cross_add;
      end
    end
  end

  // Frame-end figures held for the decision.
  logic [CW-1:0] span_r;
  logic [CW-1:0] cross_fin_r;

  always_ff @(posedge clk) begin
    if (in_fire && frame_end) begin
      span_r      <= pos_r;
      cross_fin_r <= cross_add;
    end
  end

  // ---------------------------------------------------------------------------
  // Mean energy divider
  // ---------------------------------------------------------------------------
  logic          div_start;
  logic [SW-1:0] div_quo;
  logic [EW-1:0] energy_r;

  assign div_start = in_fire && frame_end;

  vad_div #(
    .DW (SW),
    .VW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (n_cur),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Crossing-rate bounds scaled by the span, worked out while the divider runs.
  logic [PW-1:0] prod_lo_r;
  logic [PW-1:0] prod_hi_r;

  always_ff @(posedge clk) begin
    if (state_r == vad_pkg::ST_DIV) begin
      prod_lo_r <= PW'(rate_low_r) * PW'(span_r);
      prod_hi_r <= PW'(rate_high_r) * PW'(span_r);
      if (div_done) begin
        energy_r <= div_quo[EW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Energy history memory and running total
  // ---------------------------------------------------------------------------
  // The old entry is read when the frame ends and replaced in ST_HIST. The
  // sequencer handles one frame at a time, so the read and write of one entry
  // never overlap with another frame's access.
  logic [EW-1:0]            hist_mem [HISTORY_DEPTH];
  logic [EW-1:0]            rd_data_r;
  logic [HISTORY_DEPTH-1:0] hist_valid_r;
  logic [HW-1:0]            slot_r;
  logic [TW-1:0]            total_r;
  logic [TW-1:0]            total_nxt;
  logic [TW-1:0]            bg_prod_r;
  logic [EW-1:0]            old_energy;
  logic                     mem_we;

  assign mem_we = (state_r == vad_pkg::ST_HIST);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[slot_r] <= energy_r;
    end
    if (div_start) begin
      rd_data_r <= hist_mem[slot_r];
    end
  end

  // An entry never written since reset counts as zero energy.
  always_comb begin
    old_energy = hist_valid_r[slot_r] ? rd_data_r : '0;
    total_nxt  = total_r - TW'(old_energy) + TW'(energy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= '0;
      slot_r       <= '0;
      total_r      <= '0;
    end else if (mem_we) begin
      hist_valid_r[slot_r] <= 1'b1;
      slot_r               <= (slot_r == HW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      total_r              <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bg_prod_r <= TW'(energy_r) * TW'(HISTORY_DEPTH);
    end
  end

  // ---------------------------------------------------------------------------
  // Decision, counters and output register
  // ---------------------------------------------------------------------------
  logic          loud;
  logic          rate_ok;
  logic          above_bg;
  logic          active;
  logic          out_load;
  logic [PW-1:0] cross_scaled;

  always_comb begin
    cross_scaled = {cross_fin_r, {vad_pkg::RATE_W{1'b0}}};
    loud         = energy_r > threshold_r;
    rate_ok      = (cross_scaled > prod_lo_r) && (cross_scaled < prod_hi_r);
    above_bg     = {1'b0, bg_prod_r} > {total_r, 1'b0};
    active       = loud && rate_ok && above_bg;
    out_load     = (state_r == vad_pkg::ST_DEC) && out_free;
  end

  logic [vad_pkg::COUNT_W-1:0] voice_cnt_r;
  logic [vad_pkg::COUNT_W-1:0] silence_cnt_r;
  logic [vad_pkg::COUNT_W-1:0] voice_cnt_nxt;
  logic [vad_pkg::COUNT_W-1:0] silence_cnt_nxt;

  // Saturating frame counters.
  always_comb begin
    voice_cnt_nxt   = voice_cnt_r;
    silence_cnt_nxt = silence_cnt_r;
    if (active) begin
      if (voice_cnt_r != vad_pkg::COUNT_MAX) begin
        voice_cnt_nxt = voice_cnt_r + 1'b1;
      end
    end else begin
      if (silence_cnt_r != vad_pkg::COUNT_MAX) begin
        silence_cnt_nxt = silence_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_cnt_r   <= '0;
      silence_cnt_r <= '0;
    end else if (out_load) begin
      voice_cnt_r   <= voice_cnt_nxt;
      silence_cnt_r <= silence_cnt_nxt;
    end
  end

  // Output word valid flag.
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload.
  logic                            out_active_r;
  logic [vad_pkg::CONF_W-1:0]      out_conf_r;
  logic [EW-1:0]                   out_energy_r;
  logic [vad_pkg::CROSS_OUT_W-1:0] out_cross_r;
  logic [vad_pkg::COUNT_W-1:0]     out_voice_r;
  logic [vad_pkg::COUNT_W-1:0]     out_silence_r;
  logic [CXW-1:0]                  cross_wide;

  assign cross_wide = CXW'(cross_fin_r);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_active_r  <= active;
      out_conf_r    <= active ? vad_pkg::CONF_ONE : '0;
      out_energy_r  <= energy_r;
      out_cross_r   <= cross_wide[vad_pkg::CROSS_OUT_W-1:0];
      out_voice_r   <= voice_cnt_nxt;
      out_silence_r <= silence_cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_voice_active   = out_active_r;
  assign out_confidence     = out_conf_r;
  assign out_frame_energy   = out_energy_r;
  assign out_crossing_count = out_cross_r;
  assign out_voice_frames   = out_voice_r;
  assign out_silence_frames = out_silence_r;

endmodule

@@ tb/vad_frame_checker.sv @@
// Checker for the voice activity detector: watches the sample, result and configuration
// ports, predicts every result word and compares it field by field with what arrives.
// Depends on vad_pkg for field widths, register indexes and reset values.
module vad_frame_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [vad_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                out_voice_active,
  input  logic [vad_pkg::CONF_W-1:0]          out_confidence,
  input  logic [vad_pkg::ENERGY_W-1:0]        out_frame_energy,
  input  logic [vad_pkg::CROSS_OUT_W-1:0]     out_crossing_count,
  input  logic [vad_pkg::COUNT_W-1:0]         out_voice_frames,
  input  logic [vad_pkg::COUNT_W-1:0]         out_silence_frames,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [vad_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [vad_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  input  logic [vad_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  input  logic                                cfg_pready,
  output int                                  frames_pending,
  output int                                  mismatch_count
);

  localparam int HIST_DEPTH  = 16;
  localparam int FRAME_MAX   = 4096;

  typedef struct {
    logic                            voice_active;
    logic [vad_pkg::CONF_W-1:0]      confidence;
    logic [vad_pkg::ENERGY_W-1:0]    frame_energy;
    logic [vad_pkg::CROSS_OUT_W-1:0] crossing_count;
    logic [vad_pkg::COUNT_W-1:0]     voice_frames;
    logic [vad_pkg::COUNT_W-1:0]     silence_frames;
  } frame_verdict_t;

  // Register copies, updated from the writes seen on the configuration port.
  logic [vad_pkg::FLEN_W-1:0]   frame_len;
  logic [vad_pkg::ENERGY_W-1:0] threshold;
  logic [vad_pkg::RATE_W-1:0]   rate_low;
  logic [vad_pkg::RATE_W-1:0]   rate_high;

  // Frame accumulation and history state.
  logic [11:0]                  position;
  logic                         prev_negative;
  logic [42:0]                  square_sum;
  logic [11:0]                  crossings;
  logic [vad_pkg::ENERGY_W-1:0] energy_ring [HIST_DEPTH];
  logic [3:0]                   ring_slot;
  logic [34:0]                  ring_total;
  logic [vad_pkg::COUNT_W-1:0]  voice_count;
  logic [vad_pkg::COUNT_W-1:0]  silence_count;

  frame_verdict_t verdict_q[$];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Folds one sample into the running frame; at frame end the verdict word is queued.
  task automatic accumulate_sample(input logic signed [vad_pkg::SAMPLE_W-1:0] s);
    logic                         negative;
    logic [16:0]                  mag;
    logic [12:0]                  gathered;
    logic [12:0]                  limit;
    logic [42:0]                  quotient;
    logic [vad_pkg::ENERGY_W-1:0] energy;
    logic [63:0]                  span;
    logic [63:0]                  scaled;
    logic                         rate_ok;
    logic                         loud;
    logic                         above_bg;
    logic                         active;
    frame_verdict_t               v;
    negative = s[15];
    mag = negative ? 17'h10000 - {1'b0, s} : {1'b0, s};
    square_sum = square_sum + {26'd0, mag} * {26'd0, mag};
    if (position != 12'd0 && negative != prev_negative) crossings = crossings + 12'd1;
    prev_negative = negative;

    // Out of range frame lengths are clamped to the supported span.
    if (frame_len < vad_pkg::FRAME_MIN) limit = 13'(vad_pkg::FRAME_MIN);
    else if (frame_len > FRAME_MAX) limit = 13'(FRAME_MAX);
    else limit = frame_len;
    gathered = {1'b0, position} + 13'd1;

    if (gathered < limit) begin
      position = gathered[11:0];
    end else begin
      quotient = square_sum / {30'd0, gathered};
      energy = quotient[vad_pkg::ENERGY_W-1:0];

      // The ring average includes the frame just finished.
      ring_total = ring_total - {4'd0, energy_ring[ring_slot]} + {4'd0, energy};
      energy_ring[ring_slot] = energy;
      ring_slot = ring_slot + 4'd1;

      span = {51'd0, gathered} - 64'd1;
      scaled = {52'd0, crossings} << 16;
      rate_ok = (scaled > {48'd0, rate_low} * span) && (scaled < {48'd0, rate_high} * span);
      loud = energy > threshold;
      above_bg = ({33'd0, energy} * 64'd16) > ({29'd0, ring_total} * 64'd2);
      active = loud && rate_ok && above_bg;

      if (active) begin
        if (voice_count != vad_pkg::COUNT_MAX) voice_count = voice_count + 32'd1;
      end else begin
        if (silence_count != vad_pkg::COUNT_MAX) silence_count = silence_count + 32'd1;
      end

      v.voice_active   = active;
      v.confidence     = active ? vad_pkg::CONF_ONE : '0;
      v.frame_energy   = energy;
      v.crossing_count = crossings;
      v.voice_frames   = voice_count;
      v.silence_frames = silence_count;
      verdict_q.push_back(v);

      position      = '0;
      square_sum    = '0;
      crossings     = '0;
      prev_negative = 1'b0;
    end
  endtask

  // Everything is sampled at the rising edge, before the edge's own updates land.
  always @(posedge clk) begin
    frame_verdict_t                 want;
    logic [vad_pkg::CFG_DATA_W-1:0] reg_want;
    if (!rst_n) begin
      frame_len     = vad_pkg::FRAME_LENGTH_RST;
      threshold     = vad_pkg::THRESHOLD_RST;
      rate_low      = vad_pkg::RATE_LOW_RST;
      rate_high     = vad_pkg::RATE_HIGH_RST;
      position      = '0;
      prev_negative = 1'b0;
      square_sum    = '0;
      crossings     = '0;
      for (int k = 0; k < HIST_DEPTH; k++) energy_ring[k] = '0;
      ring_slot     = '0;
      ring_total    = '0;
      voice_count   = '0;
      silence_count = '0;
      verdict_q.delete();
    end else begin
      // Configuration access phase: track writes, check reads.
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (vad_pkg::reg_idx_t'(cfg_paddr[3:2]))
            vad_pkg::REG_FRAME_LENGTH:     frame_len = cfg_pwdata[vad_pkg::FLEN_W-1:0];
            vad_pkg::REG_ENERGY_THRESHOLD: threshold = cfg_pwdata[vad_pkg::ENERGY_W-1:0];
            vad_pkg::REG_RATE_LOW:         rate_low  = cfg_pwdata[vad_pkg::RATE_W-1:0];
            vad_pkg::REG_RATE_HIGH:        rate_high = cfg_pwdata[vad_pkg::RATE_W-1:0];
            default: ;
          endcase
        end else begin
          case (vad_pkg::reg_idx_t'(cfg_paddr[3:2]))
            vad_pkg::REG_FRAME_LENGTH:     reg_want = {19'd0, frame_len};
            vad_pkg::REG_ENERGY_THRESHOLD: reg_want = {1'b0, threshold};
            vad_pkg::REG_RATE_LOW:         reg_want = {16'd0, rate_low};
            default:                       reg_want = {16'd0, rate_high};
          endcase
          if (cfg_prdata !== reg_want)
            report_mismatch("register read", 64'(cfg_prdata), 64'(reg_want));
        end
      end

      // A result word only ever belongs to a frame that ended earlier.
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result word with no frame pending, frame_energy",
                          64'(out_frame_energy), 64'd0);
        end else begin
          want = verdict_q.pop_front();
          if (out_voice_active !== want.voice_active)
            report_mismatch("voice_active", 64'(out_voice_active), 64'(want.voice_active));
          if (out_confidence !== want.confidence)
            report_mismatch("confidence", 64'(out_confidence), 64'(want.confidence));
          if (out_frame_energy !== want.frame_energy)
            report_mismatch("frame_energy", 64'(out_frame_energy), 64'(want.frame_energy));
          if (out_crossing_count !== want.crossing_count)
            report_mismatch("crossing_count", 64'(out_crossing_count),
                            64'(want.crossing_count));
          if (out_voice_frames !== want.voice_frames)
            report_mismatch("voice_frames", 64'(out_voice_frames), 64'(want.voice_frames));
          if (out_silence_frames !== want.silence_frames)
            report_mismatch("silence_frames", 64'(out_silence_frames),
                            64'(want.silence_frames));
        end
      end

      if (in_valid && !in_stall) accumulate_sample(in_sample);
    end
    frames_pending <= verdict_q.size();
  end

endmodule

@@ tb/voice_activity_detector_tb.sv @@
// Top of the voice activity detector testbench: clock, reset, sample and register stimulus.
// Depends on vad_pkg, voice_activity_detector and vad_frame_checker, which does the checking.
module voice_activity_detector_tb;

  // Allows for the divider, history and decision states, with margin.
  localparam int SETTLE_CYCLES  = 64;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {SOUND_QUIET, SOUND_VOICED, SOUND_NOISE, SOUND_EXTREME} sound_t;

  logic                                clk;
  logic                                rst_n = 1'b0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [vad_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_voice_active;
  logic [vad_pkg::CONF_W-1:0]          out_confidence;
  logic [vad_pkg::ENERGY_W-1:0]        out_frame_energy;
  logic [vad_pkg::CROSS_OUT_W-1:0]     out_crossing_count;
  logic [vad_pkg::COUNT_W-1:0]         out_voice_frames;
  logic [vad_pkg::COUNT_W-1:0]         out_silence_frames;
  logic                                cfg_psel = 1'b0;
  logic                                cfg_penable = 1'b0;
  logic                                cfg_pwrite = 1'b0;
  logic [vad_pkg::CFG_ADDR_W-1:0]      cfg_paddr = '0;
  logic [vad_pkg::CFG_DATA_W-1:0]      cfg_pwdata = '0;
  logic [vad_pkg::CFG_DATA_W-1:0]      cfg_prdata;
  logic                                cfg_pready;
  int                                  frames_pending;
  int                                  mismatch_count;

  // Idling percentages of the current phase.
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;

  // Sound generator state: a style is held for roughly one frame.
  sound_t sound = SOUND_QUIET;
  int     sound_left = 0;
  int     frame_guess = 256;
  logic   voiced_negative = 1'b0;

  voice_activity_detector u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_voice_active  (out_voice_active),
    .out_confidence    (out_confidence),
    .out_frame_energy  (out_frame_energy),
    .out_crossing_count(out_crossing_count),
    .out_voice_frames  (out_voice_frames),
    .out_silence_frames(out_silence_frames),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  vad_frame_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_voice_active  (out_voice_active),
    .out_confidence    (out_confidence),
    .out_frame_energy  (out_frame_energy),
    .out_crossing_count(out_crossing_count),
    .out_voice_frames  (out_voice_frames),
    .out_silence_frames(out_silence_frames),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready),
    .frames_pending    (frames_pending),
    .mismatch_count    (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Ends the run if nothing moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  // Picks the next audio sample; voiced frames flip sign now and then so that
  // their crossing rate sits near the usual voice band.
  function automatic logic signed [vad_pkg::SAMPLE_W-1:0] next_sample();
    int                                  pick;
    logic [vad_pkg::SAMPLE_W-1:0]        mag;
    logic signed [vad_pkg::SAMPLE_W-1:0] s;
    if (sound_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 45) sound = SOUND_VOICED;
      else if (pick < 75) sound = SOUND_QUIET;
      else if (pick < 90) sound = SOUND_NOISE;
      else sound = SOUND_EXTREME;
      sound_left = frame_guess;
    end
    sound_left--;
    case (sound)
      SOUND_VOICED: begin
        if ($urandom_range(99) < 20) voiced_negative = !voiced_negative;
        mag = vad_pkg::SAMPLE_W'($urandom_range(32767, 6000));
        s = voiced_negative ? -mag : mag;
      end
      SOUND_QUIET: begin
        mag = vad_pkg::SAMPLE_W'($urandom_range(200));
        s = $urandom_range(1) ? -mag : mag;
      end
      SOUND_NOISE: s = vad_pkg::SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(3))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2: s = 16'sh0000;
          default: s = 16'shFFFF;
        endcase
      end
    endcase
    return s;
  endfunction

  // Offers one sample word, with idle cycles first, and returns once it is taken.
  task automatic send_sample(input logic signed [vad_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds the sender back until every frame that has ended has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, access cycle, then a cycle with the bus released.
  task automatic cfg_access(input logic wr, input vad_pkg::reg_idx_t idx,
                            input logic [vad_pkg::CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_registers();
    cfg_access(1'b0, vad_pkg::REG_FRAME_LENGTH, '0);
    cfg_access(1'b0, vad_pkg::REG_ENERGY_THRESHOLD, '0);
    cfg_access(1'b0, vad_pkg::REG_RATE_LOW, '0);
    cfg_access(1'b0, vad_pkg::REG_RATE_HIGH, '0);
  endtask

  // Registers change only once the block is idle and any frame end has settled.
  task automatic configure(input logic [vad_pkg::FLEN_W-1:0] flen,
                           input logic [vad_pkg::ENERGY_W-1:0] thr,
                           input logic [vad_pkg::RATE_W-1:0] lo,
                           input logic [vad_pkg::RATE_W-1:0] hi);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_access(1'b1, vad_pkg::REG_FRAME_LENGTH, {19'd0, flen});
    cfg_access(1'b1, vad_pkg::REG_ENERGY_THRESHOLD, {1'b0, thr});
    cfg_access(1'b1, vad_pkg::REG_RATE_LOW, {16'd0, lo});
    cfg_access(1'b1, vad_pkg::REG_RATE_HIGH, {16'd0, hi});
    read_registers();
    if (flen < vad_pkg::FRAME_MIN) frame_guess = vad_pkg::FRAME_MIN;
    else if (flen > 4096) frame_guess = 4096;
    else frame_guess = int'(flen);
  endtask

  initial begin
    int phase;
    int items;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset values first.
    read_registers();

    // Directed words: two-sample frames at the extremes of the sample range.
    configure(13'd2, vad_pkg::THRESHOLD_RST, vad_pkg::RATE_LOW_RST, vad_pkg::RATE_HIGH_RST);
    send_sample(16'sh7FFF); send_sample(16'sh8000);
    send_sample(16'sh8000); send_sample(16'sh8000);
    send_sample(16'sh0000); send_sample(16'sh0000);
    send_sample(16'sh0001); send_sample(16'shFFFF);
    send_sample(16'shFFFF); send_sample(16'sh0000);
    send_sample(16'sh7FFF); send_sample(16'sh7FFF);

    // Three-sample frames with a zero threshold and the widest rate band, so voice can fire.
    configure(13'd3, 31'd0, 16'd0, 16'hFFFF);
    send_sample(16'sd20000); send_sample(16'sd20000); send_sample(-16'sd20000);
    send_sample(16'sh0000);  send_sample(16'sh0000);  send_sample(16'sh0001);
    send_sample(16'sh8000);  send_sample(16'sh7FFF);  send_sample(16'sh8000);

    // Frame length shortened mid-frame, to a value below the minimum: the
    // next sample ends a three-sample frame.
    send_sample(16'sd100); send_sample(-16'sd100);
    configure(13'd0, 31'd1, 16'd0, 16'hFFFF);
    send_sample(16'sd30000);

    // Random phases, each with its own register set and one of four idling patterns.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          configure(vad_pkg::FRAME_LENGTH_RST, vad_pkg::THRESHOLD_RST,
                    vad_pkg::RATE_LOW_RST, vad_pkg::RATE_HIGH_RST);
          items = 512;
        end
        1: begin
          configure(13'd3, 31'd1, 16'd0, 16'hFFFF);
          items = 220;
        end
        2: begin
          configure(13'($urandom_range(24, 4)), 31'($urandom_range(1 << 24)),
                    vad_pkg::RATE_LOW_RST, vad_pkg::RATE_HIGH_RST);
          items = 220;
        end
        3: begin
          configure(13'd1, 31'h7FFF_FFFF, 16'hFFFF, 16'd0);
          items = 220;
        end
        4: begin
          configure(13'($urandom_range(32, 8)), 31'($urandom_range(1 << 26)),
                    16'($urandom_range(20000)), 16'($urandom_range(65535, 20000)));
          items = 220;
        end
        default: begin
          configure(13'($urandom_range(40, 5)), 31'd0, 16'd0, 16'd32768);
          items = 220;
        end
      endcase
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      sound_left = 0;
      for (int i = 0; i < items; i++) begin
        send_sample(next_sample());
        // Now and then the sender waits for every result to come out.
        if ($urandom_range(149) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && frames_pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
